@@ hdl/rgb_box_blur_window_defines.svh @@
// Assertion macros shared by the blur window modules.
`ifndef RGB_BOX_BLUR_WINDOW_DEFINES_SVH
`define RGB_BOX_BLUR_WINDOW_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define RBBW_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a condition at one edge leads to another at the next edge.
`define RBBW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/rbbw_pkg.sv @@
// Shared types, constants and register codes of the RGB box blur window.
package rbbw_pkg;

  // Kernel geometry
  localparam int unsigned KERNEL_SIZE   = 5;
  localparam int unsigned LOOKAHEAD     = 2;
  localparam int unsigned STORED_ROWS   = KERNEL_SIZE - 1;
  localparam int unsigned NUM_RES       = LOOKAHEAD + 1;
  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned MAX_HEIGHT    = 1024;

  // Field widths
  localparam int unsigned ROW_W     = 11;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned COL_SUM_W = 11;
  localparam int unsigned WIN_SUM_W = 13;
  localparam int unsigned T_W       = 2;
  localparam int unsigned DIM_W     = 11;
  localparam int unsigned WGT_W     = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_WEIGHT   = 2'd2;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 11'd480;
  localparam logic [WGT_W-1:0] TAP_WEIGHT_RST   = 16'd2621;

  // One pixel, red in the high byte
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [COL_SUM_W-1:0] red;
    logic [COL_SUM_W-1:0] green;
    logic [COL_SUM_W-1:0] blue;
  } col_sum_t;

  typedef struct packed {
    logic [WIN_SUM_W-1:0] red;
    logic [WIN_SUM_W-1:0] green;
    logic [WIN_SUM_W-1:0] blue;
  } win_sum_t;

  // Control of one item as it leaves the input stage
  typedef struct packed {
    logic             clr;
    logic             emit;
    logic             row_end;
    logic             frame_end;
    logic [T_W-1:0]   t_first;
    logic [T_W-1:0]   t_last;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } pass_ctl_t;

  // Results caused by one item, waiting for the result register
  typedef struct packed {
    win_sum_t [NUM_RES-1:0] sum;
    logic [T_W-1:0]         t_cur;
    logic [T_W-1:0]         t_last;
    logic [POS_W-1:0]       row;
    logic [POS_W-1:0]       col;
    logic                   frame_end;
  } bundle_t;

endpackage

@@ hdl/rbbw_ifs.sv @@
// Stream interfaces of the blur window: pixel beats in, result beats out.
interface rbbw_pix_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, operation, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, operation, red_in, green_in, blue_in, output ready);
endinterface

interface rbbw_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [9:0] out_row;
  logic [9:0] out_col;
  logic       last_in_run;
  logic       frame_done;

  modport source (output valid, red_out, green_out, blue_out, out_row, out_col,
                  last_in_run, frame_done, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, out_row, out_col,
                  last_in_run, frame_done, output ready);
endinterface

@@ hdl/rbbw_line_store.sv @@
// Line store: previous rows of one column per word, registered read with write bypass.
`include "rgb_box_blur_window_defines.svh"

module rbbw_line_store #(
  parameter int unsigned DEPTH  = rbbw_pkg::MAX_WIDTH_DEF,
  parameter int unsigned DATA_W = rbbw_pkg::STORED_ROWS * $bits(rbbw_pkg::rgb_t)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DATA_W-1:0]        rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [DATA_W-1:0]        wr_data_i
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_q;

  // Write the column, read the next one; take the write data on a same-address hit
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= (wr_en_i && (rd_addr_i == wr_addr_i)) ? wr_data_i : mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

  `RBBW_ASSERT_NEXT(a_ls_bypass, rd_en_i && wr_en_i && (rd_addr_i == wr_addr_i), rd_data_o == $past(wr_data_i), "line store bypass returned stale data")

endmodule

@@ hdl/rbbw_window.sv @@
// Window stage: column sums of the neighborhood and the pending result bundle.
`include "rgb_box_blur_window_defines.svh"

module rbbw_window (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          adv_i,
  input  rbbw_pkg::pass_ctl_t                           ctl_i,
  input  rbbw_pkg::rgb_t [rbbw_pkg::KERNEL_SIZE-1:0]    column_i,
  output logic                                          can_take_o,
  output logic                                          bnd_valid_o,
  output rbbw_pkg::bundle_t                             bnd_o,
  input  logic                                          pop_i
);

  rbbw_pkg::col_sum_t col_sum_q [rbbw_pkg::STORED_ROWS];
  rbbw_pkg::col_sum_t hist      [rbbw_pkg::STORED_ROWS];
  rbbw_pkg::col_sum_t new_sum;
  rbbw_pkg::win_sum_t part;
  rbbw_pkg::win_sum_t sum1;
  rbbw_pkg::win_sum_t sum0;
  rbbw_pkg::bundle_t  bnd_q;
  logic               bnd_valid_q;
  logic               bnd_last;

  function automatic rbbw_pkg::win_sum_t widen(input rbbw_pkg::col_sum_t s);
    rbbw_pkg::win_sum_t w;
    w.red   = rbbw_pkg::WIN_SUM_W'(s.red);
    w.green = rbbw_pkg::WIN_SUM_W'(s.green);
    w.blue  = rbbw_pkg::WIN_SUM_W'(s.blue);
    return w;
  endfunction

  function automatic rbbw_pkg::win_sum_t add_ws(input rbbw_pkg::win_sum_t a,
                                                input rbbw_pkg::win_sum_t b);
    rbbw_pkg::win_sum_t s;
    s.red   = a.red + b.red;
    s.green = a.green + b.green;
    s.blue  = a.blue + b.blue;
    return s;
  endfunction

  // Sum the incoming column per channel
  always_comb begin
    new_sum = '0;
    for (int k = 0; k < rbbw_pkg::KERNEL_SIZE; k++) begin
      new_sum.red   = new_sum.red   + rbbw_pkg::COL_SUM_W'(column_i[k].red);
      new_sum.green = new_sum.green + rbbw_pkg::COL_SUM_W'(column_i[k].green);
      new_sum.blue  = new_sum.blue  + rbbw_pkg::COL_SUM_W'(column_i[k].blue);
    end
  end

  // Drop the history when the position wrapped before this item
  always_comb begin
    for (int k = 0; k < rbbw_pkg::STORED_ROWS; k++) begin
      hist[k] = ctl_i.clr ? '0 : col_sum_q[k];
    end
  end

  // Window sums after the shift and after each zero column of the row-end burst
  assign part = add_ws(add_ws(widen(hist[2]), widen(hist[3])), widen(new_sum));
  assign sum1 = add_ws(part, widen(hist[1]));
  assign sum0 = add_ws(sum1, widen(hist[0]));

  // Shift the column sums, clear them at row end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < rbbw_pkg::STORED_ROWS; k++) begin
        col_sum_q[k] <= '0;
      end
    end else if (adv_i) begin
      for (int k = 0; k < rbbw_pkg::STORED_ROWS - 1; k++) begin
        col_sum_q[k] <= ctl_i.row_end ? '0 : hist[k+1];
      end
      col_sum_q[rbbw_pkg::STORED_ROWS-1] <= ctl_i.row_end ? '0 : new_sum;
    end
  end

  assign bnd_last   = (bnd_q.t_cur == bnd_q.t_last);
  assign can_take_o = !bnd_valid_q || (pop_i && bnd_last);

  // Hold the bundle valid until its last result is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bnd_valid_q <= 1'b0;
    end else if (adv_i && ctl_i.emit) begin
      bnd_valid_q <= 1'b1;
    end else if (pop_i && bnd_last) begin
      bnd_valid_q <= 1'b0;
    end
  end

  // Load a new bundle or advance to its next result
  always_ff @(posedge clk_i) begin
    if (adv_i && ctl_i.emit) begin
      bnd_q.sum[0]     <= sum0;
      bnd_q.sum[1]     <= sum1;
      bnd_q.sum[2]     <= part;
      bnd_q.t_cur      <= ctl_i.t_first;
      bnd_q.t_last     <= ctl_i.t_last;
      bnd_q.row        <= ctl_i.row;
      bnd_q.col        <= ctl_i.col;
      bnd_q.frame_end  <= ctl_i.frame_end;
    end else if (pop_i && !bnd_last) begin
      bnd_q.t_cur <= bnd_q.t_cur + rbbw_pkg::T_W'(1);
    end
  end

  assign bnd_valid_o = bnd_valid_q;
  assign bnd_o       = bnd_q;

  `RBBW_ASSERT(a_win_t_order, !bnd_valid_q || (bnd_q.t_cur <= bnd_q.t_last), "bundle index passed its last result")

endmodule

@@ hdl/rbbw_scale.sv @@
// Scale stage: weight, floor and saturate one window sum into the result register.
`include "rgb_box_blur_window_defines.svh"

module rbbw_scale (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [rbbw_pkg::WGT_W-1:0]       tap_weight_i,
  input  logic                             bnd_valid_i,
  input  rbbw_pkg::bundle_t                bnd_i,
  output logic                             pop_o,
  rbbw_res_if.source                       res_o
);

  localparam int unsigned PROD_W = rbbw_pkg::WIN_SUM_W + rbbw_pkg::WGT_W;

  rbbw_pkg::win_sum_t          sel;
  logic                        last;
  logic                        out_valid_q;
  logic [7:0]                  red_q;
  logic [7:0]                  green_q;
  logic [7:0]                  blue_q;
  logic [rbbw_pkg::POS_W-1:0]  row_q;
  logic [rbbw_pkg::POS_W-1:0]  col_q;
  logic                        last_q;
  logic                        done_q;

  function automatic logic [7:0] scale_chan(input logic [rbbw_pkg::WIN_SUM_W-1:0] s,
                                            input logic [rbbw_pkg::WGT_W-1:0] wgt);
    logic [PROD_W-1:0]              prod;
    logic [rbbw_pkg::WIN_SUM_W-1:0] q;
    prod = PROD_W'(s) * PROD_W'(wgt);
    q    = prod[PROD_W-1:rbbw_pkg::WGT_W];
    return (q > rbbw_pkg::WIN_SUM_W'(255)) ? 8'hFF : q[7:0];
  endfunction

  assign sel   = bnd_i.sum[bnd_i.t_cur];
  assign last  = (bnd_i.t_cur == bnd_i.t_last);
  assign pop_o = bnd_valid_i && (!out_valid_q || res_o.ready);

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the next result beat
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      red_q   <= scale_chan(sel.red, tap_weight_i);
      green_q <= scale_chan(sel.green, tap_weight_i);
      blue_q  <= scale_chan(sel.blue, tap_weight_i);
      row_q   <= bnd_i.row;
      col_q   <= bnd_i.col + rbbw_pkg::POS_W'(bnd_i.t_cur)
                 - rbbw_pkg::POS_W'(rbbw_pkg::LOOKAHEAD);
      last_q  <= last;
      done_q  <= bnd_i.frame_end && last;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.red_out     = red_q;
  assign res_o.green_out   = green_q;
  assign res_o.blue_out    = blue_q;
  assign res_o.out_row     = row_q;
  assign res_o.out_col     = col_q;
  assign res_o.last_in_run = last_q;
  assign res_o.frame_done  = done_q;

  `RBBW_ASSERT(a_scale_done_last, !out_valid_q || !done_q || last_q, "frame end marked on a result that is not last")

endmodule

@@ hdl/rgb_box_blur_window.sv @@
// Top level of the streaming 5x5 RGB box blur: config, position, input stage.
//
//   channel  dir  handshake            payload
//   pix_i    in   valid/ready          operation, red_in, green_in, blue_in
//   res_o    out  valid/ready          red/green/blue_out, out_row, out_col, flags
//   cfg      in   cfg_we_i (no ready)  cfg_idx_i, cfg_data_i
//
// One pixel beat is taken per cycle while pix_i.ready is high. A result passes the
// input stage with the line store read, the window stage and the result register.
// A row-end pixel causes up to three results, sent one per cycle by the result
// register; the first two pixels of the next row emit nothing and overlap that burst.
// Reset clears the position, the window and sets the register defaults; the line
// store is not cleared. A low res_o.ready holds the result and backs up into pix_i.
`include "rgb_box_blur_window_defines.svh"

module rgb_box_blur_window #(
  parameter int unsigned MAX_WIDTH = rbbw_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rbbw_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rbbw_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  rbbw_pix_if.sink                            pix_i,
  rbbw_res_if.source                          res_o
);

  localparam int unsigned AW   = $clog2(MAX_WIDTH);
  localparam int unsigned WW   = AW + 1;
  localparam int unsigned PIXW = $bits(rbbw_pkg::rgb_t);
  localparam int unsigned LS_W = rbbw_pkg::STORED_ROWS * PIXW;

  // Configuration registers
  logic [rbbw_pkg::DIM_W-1:0] frame_width_q;
  logic [rbbw_pkg::DIM_W-1:0] frame_height_q;
  logic [rbbw_pkg::WGT_W-1:0] tap_weight_q;

  // Position of the next beat
  logic [rbbw_pkg::ROW_W-1:0] in_row_q;
  logic [rbbw_pkg::ROW_W-1:0] in_row_d;
  logic [AW-1:0]              in_col_q;
  logic [AW-1:0]              in_col_d;

  // Position decode
  logic [WW-1:0]              width;
  logic [rbbw_pkg::DIM_W-1:0] height;
  logic [rbbw_pkg::ROW_W-1:0] end_row;
  logic                       wrap_col;
  logic                       wrap_row;
  logic [rbbw_pkg::ROW_W-1:0] row_a;
  logic [rbbw_pkg::ROW_W-1:0] row;
  logic [AW-1:0]              col;
  logic                       row_end;
  logic                       frame_end;
  logic                       accept;
  rbbw_pkg::pass_ctl_t        ctl_d;
  rbbw_pkg::rgb_t             pix_d;
  logic [rbbw_pkg::STORED_ROWS-1:0] mask_d;

  // Input stage
  logic                             s1_valid_q;
  rbbw_pkg::pass_ctl_t              s1_ctl_q;
  rbbw_pkg::rgb_t                   s1_pix_q;
  logic [rbbw_pkg::STORED_ROWS-1:0] s1_mask_q;
  logic [AW-1:0]                    s1_col_q;
  logic                             s1_adv;

  // Line store and window links
  logic [LS_W-1:0]                                 ls_rd_data;
  logic [LS_W-1:0]                                 ls_wr_data;
  rbbw_pkg::rgb_t [rbbw_pkg::STORED_ROWS-1:0]      ls_rows;
  rbbw_pkg::rgb_t [rbbw_pkg::KERNEL_SIZE-1:0]      column;
  logic                                            win_can_take;
  logic                                            bnd_valid;
  rbbw_pkg::bundle_t                               bnd;
  logic                                            pop;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= rbbw_pkg::FRAME_WIDTH_RST;
      frame_height_q <= rbbw_pkg::FRAME_HEIGHT_RST;
      tap_weight_q   <= rbbw_pkg::TAP_WEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rbbw_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[rbbw_pkg::DIM_W-1:0];
        rbbw_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[rbbw_pkg::DIM_W-1:0];
        rbbw_pkg::CFG_TAP_WEIGHT:   tap_weight_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp frame size
  always_comb begin
    if (frame_width_q == '0) begin
      width = WW'(1);
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      width = WW'(MAX_WIDTH);
    end else begin
      width = WW'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      height = rbbw_pkg::DIM_W'(1);
    end else if (32'(frame_height_q) > rbbw_pkg::MAX_HEIGHT) begin
      height = rbbw_pkg::DIM_W'(rbbw_pkg::MAX_HEIGHT);
    end else begin
      height = frame_height_q;
    end
    end_row = rbbw_pkg::ROW_W'(height) + rbbw_pkg::ROW_W'(rbbw_pkg::LOOKAHEAD - 1);
  end

  // Resolve the beat's position and its emission plan
  always_comb begin
    wrap_col  = (WW'(in_col_q) >= width);
    row_a     = wrap_col ? in_row_q + rbbw_pkg::ROW_W'(1) : in_row_q;
    wrap_row  = (row_a > end_row);
    row       = wrap_row ? '0 : row_a;
    col       = wrap_col ? '0 : in_col_q;
    row_end   = (WW'(col) == width - WW'(1));
    frame_end = row_end && (row == end_row);

    if (!pix_i.operation && (row < rbbw_pkg::ROW_W'(height))) begin
      pix_d = '{red: pix_i.red_in, green: pix_i.green_in, blue: pix_i.blue_in};
    end else begin
      pix_d = '0;
    end

    for (int k = 0; k < rbbw_pkg::STORED_ROWS; k++) begin
      mask_d[k] = (row >= rbbw_pkg::ROW_W'(rbbw_pkg::STORED_ROWS - k));
    end

    ctl_d.clr       = wrap_col || wrap_row;
    ctl_d.row_end   = row_end;
    ctl_d.frame_end = frame_end;
    ctl_d.emit      = (row >= rbbw_pkg::ROW_W'(rbbw_pkg::LOOKAHEAD))
                      && ((WW'(col) >= WW'(rbbw_pkg::LOOKAHEAD)) || row_end);
    ctl_d.t_first   = (WW'(col) >= WW'(rbbw_pkg::LOOKAHEAD)) ? '0
                      : rbbw_pkg::T_W'(rbbw_pkg::LOOKAHEAD) - rbbw_pkg::T_W'(col);
    ctl_d.t_last    = row_end ? rbbw_pkg::T_W'(rbbw_pkg::LOOKAHEAD) : '0;
    ctl_d.row       = rbbw_pkg::POS_W'(row - rbbw_pkg::ROW_W'(rbbw_pkg::LOOKAHEAD));
    ctl_d.col       = rbbw_pkg::POS_W'(col);

    if (row_end) begin
      in_col_d = '0;
      in_row_d = frame_end ? '0 : row + rbbw_pkg::ROW_W'(1);
    end else begin
      in_col_d = col + AW'(1);
      in_row_d = row;
    end
  end

  assign s1_adv      = s1_valid_q && (!s1_ctl_q.emit || win_can_take);
  assign pix_i.ready = !s1_valid_q || s1_adv;
  assign accept      = pix_i.valid && pix_i.ready;

  // Advance the position per accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q <= '0;
      in_col_q <= '0;
    end else if (accept) begin
      in_row_q <= in_row_d;
      in_col_q <= in_col_d;
    end
  end

  // Hold the input stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Capture the beat into the input stage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ctl_q  <= ctl_d;
      s1_pix_q  <= pix_d;
      s1_mask_q <= mask_d;
      s1_col_q  <= col;
    end
  end

  // Build the window column, masking rows above the picture
  assign ls_rows = ls_rd_data;
  always_comb begin
    for (int k = 0; k < rbbw_pkg::STORED_ROWS; k++) begin
      column[k] = s1_mask_q[k] ? ls_rows[k] : '0;
    end
    column[rbbw_pkg::KERNEL_SIZE-1] = s1_pix_q;
    for (int k = 0; k < rbbw_pkg::STORED_ROWS; k++) begin
      ls_wr_data[k*PIXW +: PIXW] = column[k+1];
    end
  end

  rbbw_line_store #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (LS_W)
  ) u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (col),
    .rd_data_o (ls_rd_data),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_col_q),
    .wr_data_i (ls_wr_data)
  );

  rbbw_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (s1_adv),
    .ctl_i       (s1_ctl_q),
    .column_i    (column),
    .can_take_o  (win_can_take),
    .bnd_valid_o (bnd_valid),
    .bnd_o       (bnd),
    .pop_i       (pop)
  );

  rbbw_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tap_weight_i (tap_weight_q),
    .bnd_valid_i  (bnd_valid),
    .bnd_i        (bnd),
    .pop_o        (pop),
    .res_o        (res_o)
  );

  `RBBW_ASSERT_NEXT(a_top_frame_wrap, accept && frame_end, (in_row_q == '0) && (in_col_q == '0), "position did not return to origin after frame end")

endmodule
